/* sv/erl_pkg.sv */
// Shared constants, codes and types for the event rate limiter.
// Used by erl_judge, erl_store and event_rate_limiter_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erl_pkg;

    localparam int TIME_BITS   = 32;
    localparam int SLOTS_DEF   = 16;
    localparam int MAX_EV_W    = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int VERDICT_W   = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_PASS  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BEGIN = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd2;

    localparam logic [MAX_EV_W-1:0]  MAX_EVENTS_RST = 5'd16;
    localparam logic [TIME_BITS-1:0] WINDOW_RST     = 32'd60;
    localparam logic [TIME_BITS-1:0] HOLD_RST       = 32'd300;

    typedef struct packed {
        logic                 holding;
        logic [TIME_BITS-1:0] hold_start;
    } t_hold_state;

    typedef struct packed {
        logic ring_we;
        logic state_we;
        logic hold_set;
    } t_upd_ctrl;

endpackage

`default_nettype wire

/* sv/erl_store.sv */
// Timestamp ring and limiter state registers (newest slot, count, hold state).
// Depends on erl_pkg for the hold state and update control types.
`timescale 1ns / 1ps
`default_nettype none

module erl_store #(
    parameter int SLOTS = erl_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  erl_pkg::t_upd_ctrl     i_ctrl,
    input  wire  [IW-1:0]                i_wr_slot,
    input  wire  [erl_pkg::TIME_BITS-1:0] i_wr_data,
    input  wire  [CW-1:0]                i_next_count,
    input  wire  [IW-1:0]                i_rd_slot,
    output logic [erl_pkg::TIME_BITS-1:0] o_rd_data,
    output logic [IW-1:0]                o_newest,
    output logic [CW-1:0]                o_count,
    output erl_pkg::t_hold_state         o_hold
);

    logic [erl_pkg::TIME_BITS-1:0] r_ring [SLOTS];
    logic [IW-1:0]                 r_newest;
    logic [CW-1:0]                 r_count;
    erl_pkg::t_hold_state          r_hold;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ring_we) begin
            r_ring[i_wr_slot] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= IW'(SLOTS - 1);
            r_count  <= '0;
            r_hold   <= '0;
        end else if (i_ctrl.state_we) begin
            r_newest       <= i_wr_slot;
            r_count        <= i_next_count;
            r_hold.holding <= i_ctrl.hold_set;
            if (i_ctrl.hold_set) begin
                r_hold.hold_start <= i_wr_data;
            end
        end
    end

    assign o_rd_data = r_ring[i_rd_slot];
    assign o_newest  = r_newest;
    assign o_count   = r_count;
    assign o_hold    = r_hold;

endmodule

`default_nettype wire

/* sv/erl_judge.sv */
// Per-event decision: hold check, expiry, limit and window test, state update.
// Depends on erl_pkg for verdict codes and the hold state and control types.
`timescale 1ns / 1ps
`default_nettype none

module erl_judge #(
    parameter int SLOTS = erl_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  wire                           i_commit,
    input  wire  [erl_pkg::TIME_BITS-1:0] i_now,
    input  wire  [erl_pkg::MAX_EV_W-1:0]  i_max_events,
    input  wire  [erl_pkg::TIME_BITS-1:0] i_window,
    input  wire  [erl_pkg::TIME_BITS-1:0] i_hold_len,
    input  wire  [IW-1:0]                 i_newest,
    input  wire  [CW-1:0]                 i_count,
    input  wire  erl_pkg::t_hold_state    i_hold,
    input  wire  [erl_pkg::TIME_BITS-1:0] i_rd_data,
    output logic [IW-1:0]                 o_rd_slot,
    output logic [IW-1:0]                 o_wr_slot,
    output logic [CW-1:0]                 o_next_count,
    output erl_pkg::t_upd_ctrl            o_ctrl,
    output logic [erl_pkg::VERDICT_W-1:0] o_verdict,
    output logic [erl_pkg::COUNT_OUT_W-1:0] o_recorded_count
);

    localparam int LW = (CW > erl_pkg::MAX_EV_W) ? CW : erl_pkg::MAX_EV_W;
    localparam int NW = (IW + 1 > LW) ? IW + 1 : LW;

    logic [LW-1:0]                 me_l;
    logic [LW-1:0]                 lim_l;
    logic [erl_pkg::TIME_BITS-1:0] held;
    logic [erl_pkg::TIME_BITS-1:0] age;
    logic                          in_hold;
    logic                          expired;
    logic [CW-1:0]                 cnt;
    logic [IW-1:0]                 nw;
    logic [NW-1:0]                 nsum;
    logic [IW-1:0]                 nxt;
    logic                          below;
    logic                          pass;
    logic [CW-1:0]                 cnt_new;
    logic [LW-1:0]                 cnt_out_l;

    always_comb begin
        me_l = LW'(i_max_events);
        if (me_l == '0) begin
            lim_l = LW'(1);
        end else if (me_l > LW'(SLOTS)) begin
            lim_l = LW'(SLOTS);
        end else begin
            lim_l = me_l;
        end
    end

    assign held    = i_now - i_hold.hold_start;
    assign in_hold = i_hold.holding && (held < i_hold_len);
    assign expired = i_hold.holding && !in_hold;
    assign cnt     = expired ? '0 : i_count;
    assign nw      = expired ? IW'(SLOTS - 1) : i_newest;

    assign nsum = NW'(nw) + NW'(1);
    assign nxt  = (nsum >= NW'(lim_l)) ? '0 : nsum[IW-1:0];

    assign below = LW'(cnt) < lim_l;
    assign age   = i_now - i_rd_data;
    assign pass  = below || (age > i_window);

    always_comb begin
        o_ctrl = '0;
        if (in_hold) begin
            o_verdict = erl_pkg::VERDICT_DROP;
            cnt_new   = i_count;
            o_wr_slot = nxt;
        end else if (pass) begin
            o_verdict       = erl_pkg::VERDICT_PASS;
            cnt_new         = below ? cnt + CW'(1) : cnt;
            o_wr_slot       = nxt;
            o_ctrl.ring_we  = i_commit;
            o_ctrl.state_we = i_commit;
        end else begin
            o_verdict       = erl_pkg::VERDICT_BEGIN;
            cnt_new         = cnt;
            o_wr_slot       = nw;
            o_ctrl.state_we = i_commit;
            o_ctrl.hold_set = 1'b1;
        end
    end

    assign o_rd_slot        = nxt;
    assign o_next_count     = cnt_new;
    assign cnt_out_l        = LW'(cnt_new);
    assign o_recorded_count = cnt_out_l[erl_pkg::COUNT_OUT_W-1:0];

endmodule

`default_nettype wire

/* sv/event_rate_limiter_top.sv */
// Event rate limiter top level: handshakes, configuration registers, pipeline.
// Depends on erl_pkg, erl_store and erl_judge.
//
// Each event carries an arrival time in seconds and yields exactly one result:
// pass, suppression begins, or dropped during hold, with the number of passed
// events recorded afterwards. One event is taken per clock cycle while the
// output is not stalled; each event is held in the input register and its
// result in the result register. The rate is set by the single ring read,
// plus a ring write and state update as the verdict needs, done between those
// registers. No clearing pass runs after reset. Configuration writes are
// always ready and must be issued only while no events are in flight.
`timescale 1ns / 1ps
`default_nettype none

module event_rate_limiter_top #(
    parameter int SLOTS = erl_pkg::SLOTS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [erl_pkg::TIME_BITS-1:0]   i_event_time,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [erl_pkg::VERDICT_W-1:0]   o_verdict,
    output logic [erl_pkg::COUNT_OUT_W-1:0] o_recorded_count,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [erl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [erl_pkg::TIME_BITS-1:0]   i_cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [erl_pkg::MAX_EV_W-1:0]    r_max_events;
    logic [erl_pkg::TIME_BITS-1:0]   r_window;
    logic [erl_pkg::TIME_BITS-1:0]   r_hold_len;

    logic                            r_in_valid;
    logic                            n_in_valid;
    logic [erl_pkg::TIME_BITS-1:0]   r_in_time;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [erl_pkg::VERDICT_W-1:0]   r_out_verdict;
    logic [erl_pkg::COUNT_OUT_W-1:0] r_out_count;

    logic                            out_free;
    logic                            in_xfer;
    logic                            commit;

    logic [IW-1:0]                   w_rd_slot;
    logic [IW-1:0]                   w_wr_slot;
    logic [erl_pkg::TIME_BITS-1:0]   w_rd_data;
    logic [IW-1:0]                   w_newest;
    logic [CW-1:0]                   w_count;
    logic [CW-1:0]                   w_next_count;
    erl_pkg::t_hold_state            w_hold;
    erl_pkg::t_upd_ctrl              w_ctrl;
    logic [erl_pkg::VERDICT_W-1:0]   w_verdict;
    logic [erl_pkg::COUNT_OUT_W-1:0] w_rec_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_events <= erl_pkg::MAX_EVENTS_RST;
            r_window     <= erl_pkg::WINDOW_RST;
            r_hold_len   <= erl_pkg::HOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                erl_pkg::CFG_MAX_EVENTS: r_max_events <= i_cfg_data[erl_pkg::MAX_EV_W-1:0];
                erl_pkg::CFG_WINDOW:     r_window     <= i_cfg_data;
                erl_pkg::CFG_HOLD:       r_hold_len   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (commit) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_time <= i_event_time;
        end
        if (commit) begin
            r_out_verdict <= w_verdict;
            r_out_count   <= w_rec_count;
        end
    end

    erl_judge #(
        .SLOTS (SLOTS)
    ) u_judge (
        .i_commit         (commit),
        .i_now            (r_in_time),
        .i_max_events     (r_max_events),
        .i_window         (r_window),
        .i_hold_len       (r_hold_len),
        .i_newest         (w_newest),
        .i_count          (w_count),
        .i_hold           (w_hold),
        .i_rd_data        (w_rd_data),
        .o_rd_slot        (w_rd_slot),
        .o_wr_slot        (w_wr_slot),
        .o_next_count     (w_next_count),
        .o_ctrl           (w_ctrl),
        .o_verdict        (w_verdict),
        .o_recorded_count (w_rec_count)
    );

    erl_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_wr_slot    (w_wr_slot),
        .i_wr_data    (r_in_time),
        .i_next_count (w_next_count),
        .i_rd_slot    (w_rd_slot),
        .o_rd_data    (w_rd_data),
        .o_newest     (w_newest),
        .o_count      (w_count),
        .o_hold       (w_hold)
    );

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_out_verdict;
    assign o_recorded_count = r_out_count;

`ifndef SYNTHESIS
    a_begin_sets_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && w_verdict == erl_pkg::VERDICT_BEGIN) |=> w_hold.holding)
        else $error("suppression start did not enter hold");

    a_drop_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && w_verdict == erl_pkg::VERDICT_DROP) |=> $stable(w_count))
        else $error("dropped event changed the stored count");

    a_pass_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == erl_pkg::VERDICT_PASS) |-> (o_recorded_count != '0))
        else $error("passed event reported an empty ring");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while pipeline had room");
`endif

endmodule

`default_nettype wire
